[rtl/mtdt_pkg.sv]
`timescale 1ns / 1ps
// types and constants shared by the deadline table cells and top level
// no dependencies

package mtdt_pkg;

    localparam int SLOT_IDX_W = 6;
    localparam int TIME_W     = 48;
    localparam int PERIOD_W   = 32;
    localparam int ID_W       = 16;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_TIME  = 2'd2;

    localparam logic [1:0] ST_SET_OK  = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_CLEARED = 2'd2;
    localparam logic [1:0] ST_FIRED   = 2'd3;

    typedef enum logic [1:0] {
        MODE_SET,
        MODE_CLEAR,
        MODE_TIME,
        MODE_NONE
    } mode_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_SET,
        CMD_CLEAR,
        CMD_FIRE
    } cmd_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_EMIT,
        S_FLUSH
    } state_t;

    typedef struct packed {
        mode_t               mode;
        logic [TIME_W-1:0]   now;
        logic [ID_W-1:0]     cid;
    } scan_t;

    typedef struct packed {
        cmd_op_t               op;
        logic [SLOT_IDX_W-1:0] idx;
        logic [ID_W-1:0]       id;
        logic [PERIOD_W-1:0]   period;
        logic [TIME_W-1:0]     deadline;
        logic                  rep;
    } cmd_t;

    typedef struct packed {
        logic                  found;
        logic [SLOT_IDX_W-1:0] idx;
        logic [TIME_W-1:0]     deadline;
        logic [ID_W-1:0]       id;
    } carry_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [PERIOD_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W-PERIOD_W+1){1'b0}}, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

[rtl/mtdt_if.sv]
`timescale 1ns / 1ps
// request and response word channels of the deadline table
// depends on nothing

interface mtdt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [47:0] now_us;
    logic [31:0] period_us;
    logic        repeat_req;
    logic [15:0] clear_id;

    modport source (output valid, op, now_us, period_us, repeat_req, clear_id, input ready);
    modport sink (input valid, op, now_us, period_us, repeat_req, clear_id, output ready);
endinterface

interface mtdt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        found;
    logic [15:0] tmr_id;
    logic        last;

    modport source (output valid, status, found, tmr_id, last, input ready);
    modport sink (input valid, status, found, tmr_id, last, output ready);
endinterface

[rtl/mtdt_cell.sv]
`timescale 1ns / 1ps
// one timer slot of the deadline table plus one registered stage of the search chain
// depends on mtdt_pkg

module mtdt_cell #(
    parameter logic [5:0] IDX = 6'd0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mtdt_pkg::scan_t  scan,
    input  mtdt_pkg::cmd_t   cmd,
    input  mtdt_pkg::carry_t carry_in,
    output mtdt_pkg::carry_t carry_out
);

    logic                          valid_reg;
    logic [mtdt_pkg::ID_W-1:0]     id_reg;
    logic [mtdt_pkg::PERIOD_W-1:0] period_reg;
    logic [mtdt_pkg::TIME_W-1:0]   deadline_reg;
    logic                          rep_reg;
    mtdt_pkg::carry_t              carry_reg;
    mtdt_pkg::carry_t              carry_next;
    logic                          take;
    logic                          hit;

    always_comb
    begin
        case (scan.mode)
            mtdt_pkg::MODE_SET:   take = !carry_in.found && !valid_reg;
            mtdt_pkg::MODE_CLEAR: take = !carry_in.found && valid_reg && (id_reg == scan.cid);
            mtdt_pkg::MODE_TIME:  take = valid_reg && (deadline_reg <= scan.now) &&
                                         (!carry_in.found || (deadline_reg < carry_in.deadline));
            default:              take = 1'b0;
        endcase
    end

    always_comb
    begin
        carry_next = carry_in;
        if (take)
        begin
            carry_next.found    = 1'b1;
            carry_next.idx      = IDX;
            carry_next.deadline = deadline_reg;
            carry_next.id       = id_reg;
        end
    end

    assign hit = (cmd.idx == IDX);
    assign carry_out = carry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
            if (hit)
            begin
                case (cmd.op)
                    mtdt_pkg::CMD_SET:   valid_reg <= 1'b1;
                    mtdt_pkg::CMD_CLEAR: valid_reg <= 1'b0;
                    mtdt_pkg::CMD_FIRE:  valid_reg <= rep_reg;
                    default:             valid_reg <= valid_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && cmd.op == mtdt_pkg::CMD_SET)
        begin
            id_reg       <= cmd.id;
            period_reg   <= cmd.period;
            deadline_reg <= cmd.deadline;
            rep_reg      <= cmd.rep;
        end
        else if (hit && cmd.op == mtdt_pkg::CMD_FIRE && rep_reg)
        begin
            deadline_reg <= mtdt_pkg::sat_add(deadline_reg, period_reg);
        end
    end

endmodule

[rtl/multi_timer_deadline_table_core.sv]
`timescale 1ns / 1ps
// top level of the timer deadline table: controller and chain of slot cells
// depends on mtdt_pkg, mtdt_if and mtdt_cell
//
// usage
// req carries one request word: set a timer, clear a timer by id, or advance time.
// rsp carries result words; the final word of each request has last set.
// set and clear give exactly one word; time gives one word per fired timer
// (up to MAX_FIRES, earliest deadline first, ties to the lowest slot), or none.
// every lookup runs through a chain of SLOTS registered cells, so one search
// spans the scan state and is followed by the decide state.
// one request is handled at a time; req.ready is high only while idle.
// a result word is held in the output register while rsp.ready is low and
// the controller waits; nothing is lost or repeated.
// reset empties every slot and sets the next id to zero; slot contents other
// than the valid bits are not cleared.

module multi_timer_deadline_table_core #(
    parameter int SLOTS     = 16,
    parameter int MAX_FIRES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mtdt_req_if.sink   req,
    mtdt_rsp_if.source rsp
);

    localparam int CNT_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int N_W   = $clog2(MAX_FIRES + 1);

    mtdt_pkg::state_t state_reg, state_next;
    mtdt_pkg::state_t after_reg, after_next;
    mtdt_pkg::scan_t  scan_reg, scan_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [N_W-1:0]   n_reg, n_next;
    logic [mtdt_pkg::PERIOD_W-1:0] period_reg;
    logic             rep_reg;
    logic [mtdt_pkg::ID_W-1:0] next_id_reg, next_id_next;
    logic             pend_reg, pend_next;
    logic [mtdt_pkg::ID_W-1:0] pend_id_reg, pend_id_next;
    logic [1:0]       st_reg, st_next;
    logic             found_reg, found_next;
    logic [mtdt_pkg::ID_W-1:0] oid_reg, oid_next;
    logic             last_reg, last_next;
    logic             cap_limit;
    mtdt_pkg::cmd_t   cmd;
    mtdt_pkg::carry_t carry [SLOTS+1];
    mtdt_pkg::carry_t best;

    assign carry[0] = '0;
    assign best = carry[SLOTS];

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            mtdt_cell #(
                .IDX (6'(g))
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .scan      (scan_reg),
                .cmd       (cmd),
                .carry_in  (carry[g]),
                .carry_out (carry[g+1])
            );
        end
    endgenerate

    assign cap_limit = ((n_reg + N_W'(1)) == N_W'(MAX_FIRES));

    assign req.ready    = (state_reg == mtdt_pkg::S_IDLE);
    assign rsp.valid    = (state_reg == mtdt_pkg::S_EMIT);
    assign rsp.status   = st_reg;
    assign rsp.found    = found_reg;
    assign rsp.tmr_id   = oid_reg;
    assign rsp.last     = last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtdt_pkg::S_IDLE:
            begin
                if (req.valid && (req.op == mtdt_pkg::OP_SET || req.op == mtdt_pkg::OP_CLEAR ||
                                  req.op == mtdt_pkg::OP_TIME))
                    state_next = mtdt_pkg::S_SCAN;
            end
            mtdt_pkg::S_SCAN:
            begin
                if (cnt_reg == '0)
                    state_next = mtdt_pkg::S_DECIDE;
            end
            mtdt_pkg::S_DECIDE:
            begin
                if (scan_reg.mode != mtdt_pkg::MODE_TIME)
                    state_next = mtdt_pkg::S_EMIT;
                else if (best.found && pend_reg)
                    state_next = mtdt_pkg::S_EMIT;
                else if (best.found)
                    state_next = cap_limit ? mtdt_pkg::S_FLUSH : mtdt_pkg::S_SCAN;
                else if (pend_reg)
                    state_next = mtdt_pkg::S_EMIT;
                else
                    state_next = mtdt_pkg::S_IDLE;
            end
            mtdt_pkg::S_EMIT:
            begin
                if (rsp.ready)
                    state_next = after_reg;
            end
            mtdt_pkg::S_FLUSH: state_next = mtdt_pkg::S_EMIT;
            default:           state_next = mtdt_pkg::S_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        after_next   = after_reg;
        scan_next    = scan_reg;
        n_next       = n_reg;
        next_id_next = next_id_reg;
        pend_next    = pend_reg;
        pend_id_next = pend_id_reg;
        st_next      = st_reg;
        found_next   = found_reg;
        oid_next     = oid_reg;
        last_next    = last_reg;
        cmd          = '0;
        cmd.op       = mtdt_pkg::CMD_NONE;
        cmd.idx      = best.idx;
        cmd.id       = next_id_reg;
        cmd.period   = period_reg;
        cmd.deadline = mtdt_pkg::sat_add(scan_reg.now, period_reg);
        cmd.rep      = rep_reg;
        case (state_reg)
            mtdt_pkg::S_IDLE:
            begin
                scan_next.now = req.now_us;
                scan_next.cid = req.clear_id;
                n_next        = '0;
                pend_next     = 1'b0;
                case (req.op)
                    mtdt_pkg::OP_SET:   scan_next.mode = mtdt_pkg::MODE_SET;
                    mtdt_pkg::OP_CLEAR: scan_next.mode = mtdt_pkg::MODE_CLEAR;
                    mtdt_pkg::OP_TIME:  scan_next.mode = mtdt_pkg::MODE_TIME;
                    default:            scan_next.mode = mtdt_pkg::MODE_NONE;
                endcase
            end
            mtdt_pkg::S_DECIDE:
            begin
                after_next = mtdt_pkg::S_IDLE;
                case (scan_reg.mode)
                    mtdt_pkg::MODE_SET:
                    begin
                        last_next  = 1'b1;
                        found_next = 1'b0;
                        if (best.found)
                        begin
                            cmd.op       = mtdt_pkg::CMD_SET;
                            st_next      = mtdt_pkg::ST_SET_OK;
                            oid_next     = next_id_reg;
                            next_id_next = next_id_reg + {{(mtdt_pkg::ID_W-1){1'b0}}, 1'b1};
                        end
                        else
                        begin
                            st_next  = mtdt_pkg::ST_FULL;
                            oid_next = '0;
                        end
                    end
                    mtdt_pkg::MODE_CLEAR:
                    begin
                        if (best.found)
                            cmd.op = mtdt_pkg::CMD_CLEAR;
                        st_next    = mtdt_pkg::ST_CLEARED;
                        found_next = best.found;
                        oid_next   = scan_reg.cid;
                        last_next  = 1'b1;
                    end
                    mtdt_pkg::MODE_TIME:
                    begin
                        st_next    = mtdt_pkg::ST_FIRED;
                        found_next = 1'b0;
                        oid_next   = pend_id_reg;
                        if (best.found)
                        begin
                            cmd.op       = mtdt_pkg::CMD_FIRE;
                            n_next       = n_reg + N_W'(1);
                            pend_next    = 1'b1;
                            pend_id_next = best.id;
                            last_next    = 1'b0;
                            after_next   = cap_limit ? mtdt_pkg::S_FLUSH : mtdt_pkg::S_SCAN;
                        end
                        else
                        begin
                            pend_next = 1'b0;
                            last_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        last_next = 1'b1;
                    end
                endcase
            end
            mtdt_pkg::S_FLUSH:
            begin
                st_next    = mtdt_pkg::ST_FIRED;
                found_next = 1'b0;
                oid_next   = pend_id_reg;
                last_next  = 1'b1;
                pend_next  = 1'b0;
                after_next = mtdt_pkg::S_IDLE;
            end
            default:
            begin
                cmd.op = mtdt_pkg::CMD_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mtdt_pkg::S_IDLE;
            after_reg   <= mtdt_pkg::S_IDLE;
            scan_reg    <= '0;
            cnt_reg     <= '0;
            n_reg       <= '0;
            next_id_reg <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            after_reg   <= after_next;
            scan_reg    <= scan_next;
            n_reg       <= n_next;
            next_id_reg <= next_id_next;
            pend_reg    <= pend_next;
            if (state_next == mtdt_pkg::S_SCAN && state_reg != mtdt_pkg::S_SCAN)
                cnt_reg <= CNT_W'(SLOTS - 1);
            else if (state_reg == mtdt_pkg::S_SCAN)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mtdt_pkg::S_IDLE)
        begin
            period_reg <= req.period_us;
            rep_reg    <= req.repeat_req;
        end
        pend_id_reg <= pend_id_next;
        st_reg      <= st_next;
        found_reg   <= found_next;
        oid_reg     <= oid_next;
        last_reg    <= last_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("result word shown while taking a request");

    a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_W'(MAX_FIRES))
        else $error("fire count above limit");

    a_set_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.op == mtdt_pkg::OP_SET) |=>
            (state_reg == mtdt_pkg::S_SCAN))
        else $error("set request did not start a search");

    a_emit_one_shot_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == mtdt_pkg::ST_SET_OK || rsp.status == mtdt_pkg::ST_FULL ||
                       rsp.status == mtdt_pkg::ST_CLEARED)) |-> rsp.last)
        else $error("set or clear result not marked last");

endmodule
